>>> sv/postfix_expression_evaluator_macros.svh
// Assertion macros for the postfix expression evaluator.
// Used by postfix_expression_evaluator.sv; expects clk and rst_n in scope.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFE_ASSERT(lbl, prop, msg)
`define PFE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/pfe_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies.
package pfe_pkg;

    localparam int DATA_W              = 32;
    localparam int SYM_W               = 8;
    localparam int DEFAULT_STACK_DEPTH = 128;
    localparam int ITER_W              = $clog2(DATA_W);

    localparam logic [SYM_W-1:0] SYM_END   = 8'h00;
    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADOP    = 3'd3,
        ST_LEFTOVER = 3'd4,
        ST_DIVZERO  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIX
    } state_t;

endpackage

>>> sv/postfix_expression_evaluator.sv
// Postfix (RPN) expression evaluator: top level with stack memory and shared ALU/divider.
// Depends on pfe_pkg and postfix_expression_evaluator_macros.svh.
//
// Takes one character per word. Digits, terminators and characters dropped after an
// error are handled in the idle state alone; + - * run a stack read, then the ALU; /
// runs a stack read, setup, 32 restoring radix-2 steps of the shared divider and a
// sign fixup, which sets the worst-case rate. The top of stack lives in a register
// and the rest in a one-write/one-read array; the fill count alone marks valid
// entries, so there is no clearing pass after reset. The result register frees the
// input while a result waits; when no operation is running, a new character is
// stalled only while the result register is full and stalled.
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sym_valid,
    output logic                             sym_stall,
    input  logic [pfe_pkg::SYM_W-1:0]        symbol,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic signed [pfe_pkg::DATA_W-1:0] value,
    output logic [2:0]                       status
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int DW     = pfe_pkg::DATA_W;
    localparam int IW     = pfe_pkg::ITER_W;

    pfe_pkg::state_t  state_reg, state_next;
    pfe_pkg::status_t err_reg, err_next;
    pfe_pkg::op_t     op_reg, op_next;
    pfe_pkg::op_t     op_dec;
    pfe_pkg::status_t term_status;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DW-1:0]     top_reg, top_next;
    logic [DW-1:0]     rd_data_reg;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [DW-1:0]     dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [IW-1:0]     iter_reg, iter_next;
    logic              res_valid_reg, res_valid_next;
    logic [DW-1:0]     value_reg, value_next;
    logic [2:0]        status_reg, status_next;

    logic [DW-1:0]     stack_mem [STACK_DEPTH];
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0]     mem_wdata;

    logic              accept, is_digit, is_op, out_free;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic [DW-1:0]     lhs, rhs, abs_lhs, abs_rhs;
    logic [DW-1:0]     prod;
    logic [DW-1:0]     shifted;
    logic [DW:0]       diff;

    assign out_free  = !res_valid_reg || !res_stall;
    assign sym_stall = (state_reg != pfe_pkg::S_IDLE) || !out_free;
    assign accept    = sym_valid && !sym_stall;
    assign is_digit  = (symbol >= pfe_pkg::SYM_ZERO) && (symbol <= pfe_pkg::SYM_NINE);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign cnt_m2    = count_reg - CNT_W'(2);

    assign lhs     = rd_data_reg;
    assign rhs     = top_reg;
    assign abs_lhs = lhs[DW-1] ? (~lhs + DW'(1)) : lhs;
    assign abs_rhs = rhs[DW-1] ? (~rhs + DW'(1)) : rhs;
    assign prod    = lhs * rhs;
    assign shifted = {rem_reg[DW-2:0], quo_reg[DW-1]};
    assign diff    = {1'b0, shifted} - {1'b0, dvs_reg};

    assign res_valid = res_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    always_comb
    begin
        is_op  = 1'b1;
        op_dec = pfe_pkg::OP_ADD;
        case (symbol)
            pfe_pkg::SYM_PLUS:  op_dec = pfe_pkg::OP_ADD;
            pfe_pkg::SYM_MINUS: op_dec = pfe_pkg::OP_SUB;
            pfe_pkg::SYM_STAR:  op_dec = pfe_pkg::OP_MUL;
            pfe_pkg::SYM_SLASH: op_dec = pfe_pkg::OP_DIV;
            default:            is_op  = 1'b0;
        endcase
    end

    always_comb
    begin
        if (err_reg != pfe_pkg::ST_OK)
            term_status = err_reg;
        else if (count_reg == '0)
            term_status = pfe_pkg::ST_EMPTY;
        else if (count_reg != CNT_W'(1))
            term_status = pfe_pkg::ST_LEFTOVER;
        else
            term_status = pfe_pkg::ST_OK;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfe_pkg::S_IDLE:
            begin
                if (accept && symbol != pfe_pkg::SYM_END && err_reg == pfe_pkg::ST_OK
                    && !is_digit && count_reg >= CNT_W'(2) && is_op)
                    state_next = pfe_pkg::S_EXEC;
            end
            pfe_pkg::S_EXEC:
            begin
                if (op_reg == pfe_pkg::OP_DIV && rhs != '0)
                    state_next = pfe_pkg::S_DIV;
                else
                    state_next = pfe_pkg::S_IDLE;
            end
            pfe_pkg::S_DIV:
            begin
                if (iter_reg == '0)
                    state_next = pfe_pkg::S_FIX;
            end
            pfe_pkg::S_FIX:
                state_next = pfe_pkg::S_IDLE;
            default:
                state_next = pfe_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        err_next       = err_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        iter_next      = iter_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg && res_stall;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = cnt_m1[ADDR_W-1:0];
        mem_raddr      = cnt_m2[ADDR_W-1:0];
        mem_wdata      = top_reg;
        case (state_reg)
            pfe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (symbol == pfe_pkg::SYM_END)
                    begin
                        res_valid_next = 1'b1;
                        status_next    = term_status;
                        value_next     = (term_status == pfe_pkg::ST_OK) ? top_reg : '0;
                        count_next     = '0;
                        err_next       = pfe_pkg::ST_OK;
                    end
                    else if (err_reg == pfe_pkg::ST_OK)
                    begin
                        if (is_digit)
                        begin
                            if (count_reg >= CNT_W'(STACK_DEPTH))
                                err_next = pfe_pkg::ST_FULL;
                            else
                            begin
                                mem_we     = (count_reg != '0);
                                top_next   = DW'(symbol - pfe_pkg::SYM_ZERO);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        else if (count_reg < CNT_W'(2))
                            err_next = pfe_pkg::ST_EMPTY;
                        else if (!is_op)
                            err_next = pfe_pkg::ST_BADOP;
                        else
                        begin
                            mem_re  = 1'b1;
                            op_next = op_dec;
                        end
                    end
                end
            end
            pfe_pkg::S_EXEC:
            begin
                case (op_reg)
                    pfe_pkg::OP_ADD:
                    begin
                        top_next   = lhs + rhs;
                        count_next = cnt_m1;
                    end
                    pfe_pkg::OP_SUB:
                    begin
                        top_next   = lhs - rhs;
                        count_next = cnt_m1;
                    end
                    pfe_pkg::OP_MUL:
                    begin
                        top_next   = prod;
                        count_next = cnt_m1;
                    end
                    pfe_pkg::OP_DIV:
                    begin
                        if (rhs == '0)
                            err_next = pfe_pkg::ST_DIVZERO;
                        else
                        begin
                            rem_next  = '0;
                            quo_next  = abs_lhs;
                            dvs_next  = abs_rhs;
                            neg_next  = lhs[DW-1] ^ rhs[DW-1];
                            iter_next = IW'(DW - 1);
                        end
                    end
                    default:
                        err_next = pfe_pkg::ST_BADOP;
                endcase
            end
            pfe_pkg::S_DIV:
            begin
                // restoring radix-2 step
                rem_next  = diff[DW] ? shifted : diff[DW-1:0];
                quo_next  = {quo_reg[DW-2:0], ~diff[DW]};
                iter_next = iter_reg - IW'(1);
            end
            pfe_pkg::S_FIX:
            begin
                top_next   = neg_reg ? (~quo_reg + DW'(1)) : quo_reg;
                count_next = cnt_m1;
            end
            default:
            begin
                res_valid_next = res_valid_reg && res_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfe_pkg::S_IDLE;
            err_reg       <= pfe_pkg::ST_OK;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        top_reg    <= top_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        iter_reg   <= iter_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // stack below the top entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= stack_mem[mem_raddr];
    end

    `PFE_ASSERT(a_count_bound, count_reg <= CNT_W'(STACK_DEPTH), "stack count past depth")
    `PFE_ASSERT(a_res_from_term, $rose(res_valid_reg) |-> $past(accept && symbol == pfe_pkg::SYM_END), "result without terminator")
    `PFE_ASSERT(a_err_zero_value, res_valid_reg && status_reg != pfe_pkg::ST_OK |-> value_reg == '0, "error result with nonzero value")
    `PFE_ASSERT(a_div_nonzero, state_reg == pfe_pkg::S_DIV |-> dvs_reg != '0, "divider running on zero divisor")
    `PFE_ASSERT(a_err_holds_stack, state_reg == pfe_pkg::S_IDLE && err_reg != pfe_pkg::ST_OK && !(accept && symbol == pfe_pkg::SYM_END) |=> $stable(count_reg), "stack changed after error")

endmodule

>>> tb/postfix_expression_evaluator_tb.sv
// Self-checking testbench for postfix_expression_evaluator: directed and random RPN words,
// a built-in stack calculator predicts each terminator's value and status.
// Depends on pfe_pkg and the postfix_expression_evaluator RTL.
`timescale 1ns / 100ps

module postfix_expression_evaluator_tb;

    localparam int  CALC_DEPTH    = pfe_pkg::DEFAULT_STACK_DEPTH;
    localparam int  LIMIT_CYCLES  = 500000;
    localparam int  TARGET_WORDS  = 1500;
    localparam int  DRAIN_CYCLES  = 100;
    localparam int  LONG_HOLD     = 400;
    localparam int  HOLD_AFTER    = 500;
    localparam logic [pfe_pkg::SYM_W-1:0] SYM_TOP_BYTE = 8'hFF;

    typedef struct packed {
        logic signed [pfe_pkg::DATA_W-1:0] value;
        pfe_pkg::status_t                  status;
    } result_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              sym_valid = 1'b0;
    logic                              sym_stall;
    logic [pfe_pkg::SYM_W-1:0]         symbol    = pfe_pkg::SYM_END;
    logic                              res_valid;
    logic                              res_stall = 1'b0;
    logic signed [pfe_pkg::DATA_W-1:0] value;
    logic [2:0]                        status;

    logic [pfe_pkg::SYM_W-1:0] sym_queue[$];
    result_t                   want_results[$];

    logic [pfe_pkg::DATA_W-1:0] calc_stack[CALC_DEPTH];
    int                         calc_depth = 0;
    pfe_pkg::status_t           calc_err   = pfe_pkg::ST_OK;

    int total_words = 0;
    int acc_cnt     = 0;
    int sent_cnt    = 0;
    int fail_cnt    = 0;
    int cycles      = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int stall_mode  = 0;
    int mode_left   = 0;

    postfix_expression_evaluator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .symbol    (symbol),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .value     (value),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string what);
        begin
            fail_cnt++;
            if (fail_cnt <= 100)
                $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Stack calculator; a terminator queues one expected result.
    function automatic void calc_symbol(input logic [pfe_pkg::SYM_W-1:0] sym);
        logic [pfe_pkg::DATA_W-1:0] lhs, rhs, res, mag_l, mag_r, quo;
        result_t                    r;
        bit                         ok;
        begin
            res = '0;
            ok  = 1'b1;
            if (sym == pfe_pkg::SYM_END)
            begin
                r.value = '0;
                if (calc_err != pfe_pkg::ST_OK)
                    r.status = calc_err;
                else if (calc_depth == 0)
                    r.status = pfe_pkg::ST_EMPTY;
                else if (calc_depth != 1)
                    r.status = pfe_pkg::ST_LEFTOVER;
                else
                begin
                    r.status = pfe_pkg::ST_OK;
                    r.value  = calc_stack[0];
                end
                want_results.push_back(r);
                calc_depth = 0;
                calc_err   = pfe_pkg::ST_OK;
            end
            else if (calc_err == pfe_pkg::ST_OK)
            begin
                if (sym >= pfe_pkg::SYM_ZERO && sym <= pfe_pkg::SYM_NINE)
                begin
                    if (calc_depth >= CALC_DEPTH)
                        calc_err = pfe_pkg::ST_FULL;
                    else
                    begin
                        calc_stack[calc_depth] = pfe_pkg::DATA_W'(sym - pfe_pkg::SYM_ZERO);
                        calc_depth++;
                    end
                end
                else if (calc_depth < 2)
                    calc_err = pfe_pkg::ST_EMPTY;
                else
                begin
                    rhs = calc_stack[calc_depth-1];
                    lhs = calc_stack[calc_depth-2];
                    case (sym)
                        pfe_pkg::SYM_PLUS:  res = lhs + rhs;
                        pfe_pkg::SYM_MINUS: res = lhs - rhs;
                        pfe_pkg::SYM_STAR:  res = lhs * rhs;
                        pfe_pkg::SYM_SLASH:
                        begin
                            if (rhs == '0)
                            begin
                                calc_err = pfe_pkg::ST_DIVZERO;
                                ok       = 1'b0;
                            end
                            else
                            begin
                                mag_l = lhs[pfe_pkg::DATA_W-1] ? -lhs : lhs;
                                mag_r = rhs[pfe_pkg::DATA_W-1] ? -rhs : rhs;
                                quo   = mag_l / mag_r;
                                res   = (lhs[pfe_pkg::DATA_W-1] != rhs[pfe_pkg::DATA_W-1])
                                        ? -quo : quo;
                            end
                        end
                        default:
                        begin
                            calc_err = pfe_pkg::ST_BADOP;
                            ok       = 1'b0;
                        end
                    endcase
                    if (ok)
                    begin
                        calc_depth--;
                        calc_stack[calc_depth-1] = res;
                    end
                end
            end
        end
    endfunction

    function automatic logic [pfe_pkg::SYM_W-1:0] rand_digit();
        return pfe_pkg::SYM_ZERO + pfe_pkg::SYM_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [pfe_pkg::SYM_W-1:0] rand_op(input int div_pct);
        int pick;
        begin
            if ($urandom_range(0, 99) < div_pct)
                return pfe_pkg::SYM_SLASH;
            pick = $urandom_range(0, 2);
            if (pick == 0)
                return pfe_pkg::SYM_PLUS;
            else if (pick == 1)
                return pfe_pkg::SYM_MINUS;
            return pfe_pkg::SYM_STAR;
        end
    endfunction

    task automatic add_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                sym_queue.push_back(pfe_pkg::SYM_W'(s[i]));
            sym_queue.push_back(pfe_pkg::SYM_END);
        end
    endtask

    // Well-formed expression of n operands, optionally with one word overwritten.
    task automatic add_expr(input int n, input int div_pct, input bit push_first,
                            input bit corrupt);
        logic [pfe_pkg::SYM_W-1:0] q[$];
        int                        pushed;
        int                        depth;
        begin
            pushed = 0;
            depth  = 0;
            while (pushed < n || depth > 1)
            begin
                if (pushed < n && (depth < 2 || push_first || $urandom_range(0, 1) == 0))
                begin
                    q.push_back(rand_digit());
                    pushed++;
                    depth++;
                end
                else
                begin
                    q.push_back(rand_op(div_pct));
                    depth--;
                end
            end
            if (corrupt && q.size() > 0)
                q[$urandom_range(0, q.size() - 1)] = pfe_pkg::SYM_W'($urandom_range(0, 255));
            foreach (q[i])
                sym_queue.push_back(q[i]);
            sym_queue.push_back(pfe_pkg::SYM_END);
        end
    endtask

    // 2^31 built from repeated doubling, then an optional tail; or a power of nine.
    task automatic add_extreme();
        int pick;
        begin
            pick = $urandom_range(0, 4);
            if (pick == 4)
            begin
                sym_queue.push_back(pfe_pkg::SYM_NINE);
                repeat ($urandom_range(1, 12))
                begin
                    sym_queue.push_back(pfe_pkg::SYM_NINE);
                    sym_queue.push_back(pfe_pkg::SYM_STAR);
                end
            end
            else
            begin
                sym_queue.push_back(pfe_pkg::SYM_ZERO + 8'd2);
                repeat (30)
                begin
                    sym_queue.push_back(pfe_pkg::SYM_ZERO + 8'd2);
                    sym_queue.push_back(pfe_pkg::SYM_STAR);
                end
                if (pick != 0)
                begin
                    sym_queue.push_back(pfe_pkg::SYM_ZERO);
                    sym_queue.push_back(pfe_pkg::SYM_ZERO + 8'd1);
                    sym_queue.push_back(pfe_pkg::SYM_MINUS);
                    sym_queue.push_back(pick == 1 ? pfe_pkg::SYM_SLASH : pfe_pkg::SYM_STAR);
                end
                if (pick == 3)
                begin
                    sym_queue.push_back(pfe_pkg::SYM_ZERO + 8'd1);
                    sym_queue.push_back(pfe_pkg::SYM_PLUS);
                end
            end
            sym_queue.push_back(pfe_pkg::SYM_END);
        end
    endtask

    task automatic add_noise();
        begin
            repeat ($urandom_range(0, 12))
                sym_queue.push_back(pfe_pkg::SYM_W'($urandom_range(0, 255)));
            sym_queue.push_back(pfe_pkg::SYM_END);
        end
    endtask

    task automatic add_overflow();
        begin
            repeat (CALC_DEPTH + $urandom_range(1, 3))
                sym_queue.push_back(rand_digit());
            repeat ($urandom_range(0, 3))
                sym_queue.push_back(rand_op(20));
            sym_queue.push_back(pfe_pkg::SYM_END);
        end
    endtask

    // Word driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            sym_valid <= 1'b0;
        else if (sym_valid && acc_cnt != sent_cnt)
            ;
        else if (gap_left > 0)
        begin
            sym_valid <= 1'b0;
            gap_left  = gap_left - 1;
        end
        else if (sym_queue.size() > 0)
        begin
            symbol    <= sym_queue.pop_front();
            sym_valid <= 1'b1;
            sent_cnt  <= sent_cnt + 1;
            if (burst_left <= 1)
            begin
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                burst_left = burst_left - 1;
        end
        else
            sym_valid <= 1'b0;
    end

    // Result stall: one long hold, otherwise phases of none, light and heavy stalling.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (!hold_done && acc_cnt >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            res_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 300);
            end
            else
                mode_left = mode_left - 1;
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                default: res_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: predict on accepted words, then check accepted results.
    always @(posedge clk)
    begin
        result_t w;
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            if (rst_n && sym_valid && !sym_stall)
            begin
                acc_cnt <= acc_cnt + 1;
                calc_symbol(symbol);
            end
            if (rst_n && res_valid && !res_stall)
            begin
                if (want_results.size() == 0)
                    report($sformatf("unexpected result value=%0d status=%0d", value, status));
                else
                begin
                    w = want_results.pop_front();
                    if (value !== w.value)
                        report($sformatf("value %0d, want %0d", value, w.value));
                    if (status !== w.status)
                        report($sformatf("status %0d, want %0d", status, w.status));
                end
            end
        end
    end

    initial
    begin
        int kind;

        add_text("");
        add_text("9");
        add_text("12");
        add_text("x");
        add_text("80/");
        add_text("07-2/");
        add_text("34*5+");
        sym_queue.push_back(pfe_pkg::SYM_ZERO + 8'd1);
        sym_queue.push_back(pfe_pkg::SYM_ZERO + 8'd2);
        sym_queue.push_back(SYM_TOP_BYTE);
        sym_queue.push_back(pfe_pkg::SYM_END);

        while (sym_queue.size() < TARGET_WORDS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 66)
                add_expr($urandom_range(1, 8), 15, 1'b0, 1'b0);
            else if (kind < 71)
                add_expr(($urandom_range(0, 4) == 0) ? CALC_DEPTH : $urandom_range(20, 127),
                         3, ($urandom_range(0, 1) == 1), 1'b0);
            else if (kind < 74)
                add_overflow();
            else if (kind < 80)
                add_extreme();
            else if (kind < 90)
                add_expr($urandom_range(1, 6), 15, 1'b0, 1'b1);
            else
                add_noise();
        end
        total_words = sym_queue.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (sym_queue.size() != 0 || acc_cnt != total_words)
            @(posedge clk);
        while (want_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0 && want_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/pfe_pkg.sv
sv/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_tb.sv
